>>> src/phase_angle_triac_firing_defines.svh
// Assertion macros for the phase-angle triac trigger.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef PHASE_ANGLE_TRIAC_FIRING_DEFINES_SVH
`define PHASE_ANGLE_TRIAC_FIRING_DEFINES_SVH

`ifndef SYNTH
`define PATF_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define PATF_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");
`else
`define PATF_ASSERT(lbl, clk, rst_n, prop)
`define PATF_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

>>> src/patf_pkg.sv
// Shared constants and controller/datapath interface types for the triac trigger.
// No dependencies.
package patf_pkg;

    localparam int PULSE_COUNTS_DEF = 399;
    localparam int COUNT_WIDTH_DEF  = 16;

    localparam int ANGLE_W = 15;
    localparam int FREQ_W  = 13;
    localparam int FIX_W   = 14;
    localparam int CFG_W   = 15;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_ANGLE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FREQ   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FIX    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 2'd3;

    localparam logic [ANGLE_W-1:0] ANGLE_RST = 15'd9000;
    localparam logic [FREQ_W-1:0]  FREQ_RST  = 13'd6000;
    localparam logic [FIX_W-1:0]   FIX_RST   = 14'd1000;

    // delay = angle * 50000 / (9 * freq): angle in 0.01 deg, freq in 0.01 Hz, 0.5 us ticks
    localparam int ANGLE_SCALE = 50000;
    localparam int FREQ_SCALE  = 9;
    localparam int NUM_W = 31;   // 32767 * 50000 < 2^31
    localparam int DEN_W = 17;   // 8191 * 9 < 2^17
    localparam int DIV_STEPS = NUM_W;
    localparam int STEP_CNT_W = $clog2(DIV_STEPS);
    localparam int SUM_W = NUM_W + 3;

    typedef struct packed {
        logic busy;     // delay recompute in progress, input held off
        logic load;     // register product and divisor
        logic step;     // one restoring divide step
        logic finish;   // apply correction and saturate
    } t_cmd;

    typedef struct packed {
        logic skid_full;
    } t_sts;

endpackage

>>> src/patf_ctrl.sv
// Controller for the delay recompute sequence: load, divide steps, finish.
// Depends on patf_pkg.
module patf_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  patf_pkg::t_sts  i_sts,
    output patf_pkg::t_cmd  o_cmd,
    output logic            o_in_stall
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOAD = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    localparam logic [patf_pkg::STEP_CNT_W-1:0] LAST_STEP =
        patf_pkg::STEP_CNT_W'(patf_pkg::DIV_STEPS - 1);

    logic [1:0] r_state, n_state;
    logic [patf_pkg::STEP_CNT_W-1:0] r_step, n_step;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        unique case (r_state)
            S_IDLE: n_state = S_IDLE;
            S_LOAD: begin
                n_state = S_DIV;
                n_step  = '0;
            end
            S_DIV: begin
                n_step = r_step + 1'b1;
                if (r_step == LAST_STEP) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
        // any register write restarts the recompute with the new values
        if (i_cfg_we) begin
            n_state = S_LOAD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_comb begin
        o_cmd.busy   = (r_state != S_IDLE);
        o_cmd.load   = (r_state == S_LOAD);
        o_cmd.step   = (r_state == S_DIV);
        o_cmd.finish = (r_state == S_FIN);
    end

    assign o_in_stall = o_cmd.busy || i_sts.skid_full;

endmodule

>>> src/patf_dp.sv
// Datapath: config registers, delay divider, firing counter and output queue.
// Depends on patf_pkg and phase_angle_triac_firing_defines.svh.
`include "phase_angle_triac_firing_defines.svh"

module patf_dp #(
    parameter int PULSE_COUNTS = patf_pkg::PULSE_COUNTS_DEF,
    parameter int COUNT_WIDTH  = patf_pkg::COUNT_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [patf_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [patf_pkg::CFG_W-1:0]        i_cfg_data,
    input  patf_pkg::t_cmd                    i_cmd,
    output patf_pkg::t_sts                    o_sts,
    input  logic                              i_in_valid,
    input  logic                              i_zero_cross_edge,
    input  logic                              i_tick,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_gate,
    output logic                              o_busy_res
);

    localparam int DELAY_MAX = (2 ** COUNT_WIDTH) - 1 - PULSE_COUNTS;
    localparam int NUM_W = patf_pkg::NUM_W;
    localparam int DEN_W = patf_pkg::DEN_W;
    localparam int SUM_W = patf_pkg::SUM_W;
    localparam int FIX_W = patf_pkg::FIX_W;

    // config registers
    logic [patf_pkg::ANGLE_W-1:0] r_angle;
    logic [patf_pkg::FREQ_W-1:0]  r_freq;
    logic [FIX_W-1:0]             r_fix;
    logic                         r_enable;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle  <= patf_pkg::ANGLE_RST;
            r_freq   <= patf_pkg::FREQ_RST;
            r_fix    <= patf_pkg::FIX_RST;
            r_enable <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                patf_pkg::REG_ANGLE:  r_angle  <= i_cfg_data[patf_pkg::ANGLE_W-1:0];
                patf_pkg::REG_FREQ:   r_freq   <= i_cfg_data[patf_pkg::FREQ_W-1:0];
                patf_pkg::REG_FIX:    r_fix    <= i_cfg_data[FIX_W-1:0];
                patf_pkg::REG_ENABLE: r_enable <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // restoring divider; r_num shifts out dividend bits and collects quotient bits
    logic [NUM_W-1:0]      r_num;
    logic [DEN_W-1:0]      r_den;
    logic [DEN_W:0]        r_rem;
    logic [DEN_W:0]        trial;
    logic                  qbit;
    logic [COUNT_WIDTH-1:0] r_calc;
    logic signed [SUM_W-1:0] total;
    logic signed [SUM_W-1:0] fix_ext;

    assign trial = {r_rem[DEN_W-1:0], r_num[NUM_W-1]};
    assign qbit  = (trial >= {1'b0, r_den});
    assign fix_ext = SUM_W'(signed'(r_fix));
    assign total = signed'({3'b000, r_num}) + (fix_ext <<< 1) - SUM_W'(1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_num <= NUM_W'(32'(r_angle) * 32'(patf_pkg::ANGLE_SCALE));
            r_den <= DEN_W'(DEN_W'(r_freq) * DEN_W'(patf_pkg::FREQ_SCALE));
            r_rem <= '0;
        end else if (i_cmd.step) begin
            r_rem <= qbit ? (trial - {1'b0, r_den}) : trial;
            r_num <= {r_num[NUM_W-2:0], qbit};
        end
        if (i_cmd.finish) begin
            if (r_den == '0) begin
                r_calc <= COUNT_WIDTH'(DELAY_MAX);
            end else if (total[SUM_W-1]) begin
                r_calc <= '0;
            end else if (total > signed'(SUM_W'(DELAY_MAX))) begin
                r_calc <= COUNT_WIDTH'(DELAY_MAX);
            end else begin
                r_calc <= total[COUNT_WIDTH-1:0];
            end
        end
    end

    // firing counter; armed is simply the complement of running
    logic                   r_running;
    logic                   r_gate;
    logic [COUNT_WIDTH-1:0] r_count;
    logic [COUNT_WIDTH-1:0] r_delay;
    logic                   acc;
    logic                   start;
    logic [COUNT_WIDTH-1:0] eff_delay;
    logic [COUNT_WIDTH-1:0] n_count;
    logic                   n_running;
    logic                   n_gate;
    logic                   r_out_v, r_skid_v;
    logic                   r_out_gate, r_out_busy;
    logic                   r_skid_gate, r_skid_busy;
    logic                   pop;

    assign acc   = i_in_valid && !i_cmd.busy && !r_skid_v;
    assign start = i_zero_cross_edge && r_enable && !r_running;
    // idle steps follow the freshly computed delay; a firing keeps the one it started with
    assign eff_delay = r_running ? r_delay : r_calc;

    always_comb begin
        n_count   = r_count;
        n_running = r_running;
        n_gate    = r_gate;
        if (start) begin
            n_count   = '0;
            n_running = 1'b1;
        end else if (r_running && i_tick) begin
            n_count = r_count + 1'b1;
        end
        if (n_running) begin
            if (n_count == eff_delay) begin
                n_gate = 1'b1;
            end
            if (n_count == COUNT_WIDTH'(eff_delay + COUNT_WIDTH'(PULSE_COUNTS))) begin
                n_gate    = 1'b0;
                n_running = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running <= 1'b0;
            r_gate    <= 1'b0;
            r_count   <= '0;
        end else if (acc) begin
            r_running <= n_running;
            r_gate    <= n_gate;
            r_count   <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_delay <= eff_delay;
        end
    end

    // output register plus skid stage
    assign pop = r_out_v && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            if (!r_out_v || pop) begin
                r_out_v  <= r_skid_v || acc;
                r_skid_v <= r_skid_v && acc;
            end else if (acc) begin
                r_skid_v <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_v || pop) begin
            if (r_skid_v) begin
                r_out_gate <= r_skid_gate;
                r_out_busy <= r_skid_busy;
            end else begin
                r_out_gate <= n_gate;
                r_out_busy <= n_running;
            end
        end
        if (acc && (r_skid_v || (r_out_v && !pop))) begin
            r_skid_gate <= n_gate;
            r_skid_busy <= n_running;
        end
    end

    assign o_out_valid     = r_out_v;
    assign o_gate          = r_out_gate;
    assign o_busy_res      = r_out_busy;
    assign o_sts.skid_full = r_skid_v;

    `PATF_ASSERT(a_skid_behind_out, i_clk, i_rst_n, r_skid_v |-> r_out_v)
    `PATF_ASSERT(a_gate_only_firing, i_clk, i_rst_n, r_gate |-> r_running)
    `PATF_ASSERT(a_no_beat_while_calc, i_clk, i_rst_n, i_cmd.busy |-> !acc)
    `PATF_ASSERT(a_start_runs, i_clk, i_rst_n, (acc && start) |=> r_running)

endmodule

>>> src/phase_angle_triac_firing.sv
// Phase-angle triac trigger. Each input beat carries one zero-cross flag and one
// 0.5 us tick flag and yields one output beat with the gate level and busy flag.
// An enabled crossing while idle starts a tick counter; the gate rises when the
// count reaches the delay and falls PULSE_COUNTS ticks later. The delay is
// angle*50000/(9*freq) + 2*fix - 1, saturated to 0..2^COUNT_WIDTH-1-PULSE_COUNTS.
// Rate: one beat per clock while no recompute runs and the skid stage is empty.
// After reset and every register write the input stalls for a multiply, 31 steps of
// the bit-serial restoring divider and a saturate. Output goes through a register
// and a skid stage, so one beat is still taken while a result waits.
// Depends on patf_pkg, patf_ctrl and patf_dp.
module phase_angle_triac_firing #(
    parameter int PULSE_COUNTS = patf_pkg::PULSE_COUNTS_DEF,
    parameter int COUNT_WIDTH  = patf_pkg::COUNT_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [patf_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [patf_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_zero_cross_edge,
    input  logic                           i_tick,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_gate,
    output logic                           o_busy_res
);

    patf_pkg::t_cmd cmd;
    patf_pkg::t_sts sts;

    patf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    patf_dp #(
        .PULSE_COUNTS (PULSE_COUNTS),
        .COUNT_WIDTH  (COUNT_WIDTH)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_in_valid        (i_in_valid),
        .i_zero_cross_edge (i_zero_cross_edge),
        .i_tick            (i_tick),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_gate            (o_gate),
        .o_busy_res        (o_busy_res)
    );

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for phase_angle_triac_firing: directed and random beats,
// checked against an in-bench predictor of the trigger. Depends on patf_pkg and the RTL.
module tb_top;

    localparam int PULSE = patf_pkg::PULSE_COUNTS_DEF;
    localparam int CW    = patf_pkg::COUNT_WIDTH_DEF;
    localparam int ANGLE_BITS = patf_pkg::ANGLE_W;
    localparam int FREQ_BITS  = patf_pkg::FREQ_W;
    localparam int FIX_BITS   = patf_pkg::FIX_W;
    localparam int DATA_BITS  = patf_pkg::CFG_W;
    localparam int IDX_BITS   = patf_pkg::CFG_IDX_W;
    localparam longint DELAY_CAP = (longint'(1) << CW) - 1 - PULSE;
    localparam int CYCLE_LIMIT = 400_000;
    localparam int HOLD_CYCLES = 80;

    typedef struct packed {
        logic gate;
        logic busy;
    } t_trigger_levels;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} t_stall_mode;

    logic                 i_clk;
    logic                 i_rst_n           = 1'b0;
    logic                 i_cfg_we          = 1'b0;
    logic [IDX_BITS-1:0]  i_cfg_idx         = '0;
    logic [DATA_BITS-1:0] i_cfg_data        = '0;
    logic                 i_in_valid        = 1'b0;
    logic                 i_zero_cross_edge = 1'b0;
    logic                 i_tick            = 1'b0;
    logic                 i_out_stall       = 1'b0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    logic                 o_gate;
    logic                 o_busy_res;

    phase_angle_triac_firing #(
        .PULSE_COUNTS(PULSE),
        .COUNT_WIDTH (CW)
    ) i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_zero_cross_edge(i_zero_cross_edge),
        .i_tick           (i_tick),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_gate           (o_gate),
        .o_busy_res       (o_busy_res)
    );

    // predictor copy of the registers and the firing state
    logic [ANGLE_BITS-1:0]      cfg_angle;
    logic [FREQ_BITS-1:0]       cfg_freq;
    logic signed [FIX_BITS-1:0] cfg_fix;
    logic                       cfg_en;
    logic                       trig_armed;
    logic                       trig_running;
    logic                       trig_gate;
    logic [CW-1:0]              trig_count;
    logic [CW-1:0]              trig_delay;

    t_trigger_levels level_q[$];

    int error_count     = 0;
    int beats_sent      = 0;
    int results_checked = 0;
    int cfg_updates     = 0;
    int gate_pulses     = 0;
    int firings_done    = 0;
    int cycle_count     = 0;
    int burst_left      = 0;
    int hold_cnt        = 0;
    int stall_left      = 0;
    // hold requests come from the tests, the receiver marks them served
    int hold_reqs       = 0;
    int hold_served     = 0;
    t_stall_mode stall_mode = STALL_NONE;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [CW-1:0] firing_delay();
        longint den;
        longint total;
        den = longint'(patf_pkg::FREQ_SCALE) * longint'(cfg_freq);
        if (den == 0)
            return CW'(DELAY_CAP);
        total = longint'(cfg_angle) * longint'(patf_pkg::ANGLE_SCALE) / den
                + 2 * longint'(cfg_fix) - 1;
        if (total < 0)
            total = 0;
        else if (total > DELAY_CAP)
            total = DELAY_CAP;
        return CW'(total);
    endfunction

    function automatic void trigger_reset();
        cfg_angle    = patf_pkg::ANGLE_RST;
        cfg_freq     = patf_pkg::FREQ_RST;
        cfg_fix      = patf_pkg::FIX_RST;
        cfg_en       = 1'b0;
        trig_armed   = 1'b1;
        trig_running = 1'b0;
        trig_gate    = 1'b0;
        trig_count   = '0;
        trig_delay   = firing_delay();
    endfunction

    function automatic void trigger_step(input logic zc, input logic tk);
        logic [CW-1:0] end_count;
        // delay tracks the registers only while idle
        if (!trig_running)
            trig_delay = firing_delay();
        // a crossing wins over a tick in the same beat
        if (zc && cfg_en && trig_armed && !trig_running) begin
            trig_armed   = 1'b0;
            trig_running = 1'b1;
            trig_count   = '0;
        end else if (trig_running && tk) begin
            trig_count = trig_count + 1'b1;
        end
        if (trig_running) begin
            end_count = trig_delay + CW'(PULSE);
            if (trig_count == trig_delay) begin
                if (!trig_gate)
                    gate_pulses++;
                trig_gate = 1'b1;
            end
            if (trig_count == end_count) begin
                trig_gate    = 1'b0;
                trig_running = 1'b0;
                trig_armed   = 1'b1;
                trig_delay   = firing_delay();
                firings_done++;
            end
        end
        level_q.push_back('{gate: trig_gate, busy: trig_running});
    endfunction

    // result beat checker
    always @(posedge i_clk) begin : check_levels
        t_trigger_levels want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (level_q.size() == 0) begin
                $error("result beat with nothing expected: gate=%0b busy_res=%0b",
                       o_gate, o_busy_res);
                error_count++;
            end else begin
                want = level_q.pop_front();
                results_checked++;
                if (o_gate !== want.gate) begin
                    $error("gate mismatch: expected %0b, actual %0b", want.gate, o_gate);
                    error_count++;
                end
                if (o_busy_res !== want.busy) begin
                    $error("busy_res mismatch: expected %0b, actual %0b",
                           want.busy, o_busy_res);
                    error_count++;
                end
            end
        end
    end

    // receiver: long hold on request, otherwise a changing stall pattern
    always @(posedge i_clk) begin
        if (hold_served != hold_reqs) begin
            hold_cnt++;
            i_out_stall <= 1'b1;
            if (hold_cnt == HOLD_CYCLES) begin
                hold_cnt    = 0;
                hold_served = hold_reqs;
            end
        end else begin
            if (stall_left == 0) begin
                stall_mode = t_stall_mode'($urandom_range(0, 3));
                stall_left = $urandom_range(16, 160);
            end
            stall_left--;
            case (stall_mode)
                STALL_NONE:  i_out_stall <= 1'b0;
                STALL_LIGHT: i_out_stall <= ($urandom_range(0, 3) == 0);
                STALL_HEAVY: i_out_stall <= ($urandom_range(0, 1) == 0);
                default:     i_out_stall <= ((stall_left % 7) < 3);
            endcase
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, level_q.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // valid is raised here and only lowered by idle_gap/drain, never in the same step
    task automatic send_beat(input logic zc, input logic tk);
        i_in_valid        <= 1'b1;
        i_zero_cross_edge <= zc;
        i_tick            <= tk;
        do @(posedge i_clk); while (o_in_stall);
        trigger_step(zc, tk);
        beats_sent++;
    endtask

    task automatic idle_gap(input int n);
        if (n > 0) begin
            i_in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic paced_beat(input logic zc, input logic tk);
        if (burst_left == 0) begin
            idle_gap($urandom_range(0, 1) ? 0 : $urandom_range(1, 6));
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        send_beat(zc, tk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (level_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [IDX_BITS-1:0] idx, input logic [DATA_BITS-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    // only called with nothing outstanding
    task automatic apply_cfg(input logic [ANGLE_BITS-1:0] angle,
                             input logic [FREQ_BITS-1:0] freq,
                             input logic [FIX_BITS-1:0] fix, input logic en);
        write_reg(patf_pkg::REG_ANGLE, DATA_BITS'(angle));
        write_reg(patf_pkg::REG_FREQ, DATA_BITS'(freq));
        write_reg(patf_pkg::REG_FIX, {fix[FIX_BITS-1], fix});
        write_reg(patf_pkg::REG_ENABLE, DATA_BITS'(en));
        i_cfg_we  <= 1'b0;
        cfg_angle = angle;
        cfg_freq  = freq;
        cfg_fix   = fix;
        cfg_en    = en;
        cfg_updates++;
    endtask

    task automatic test_reset_defaults();
        // disabled after reset: crossings must be ignored
        paced_beat(1'b1, 1'b1);
        paced_beat(1'b0, 1'b0);
        paced_beat(1'b1, 1'b0);
        paced_beat(1'b0, 1'b1);
    endtask

    task automatic test_register_extremes();
        // zero frequency saturates the delay, full-scale angle and fix
        drain();
        apply_cfg('1, '0, 14'h1FFF, 1'b0);
        paced_beat(1'b1, 1'b1);
        paced_beat(1'b0, 1'b1);
        // most negative fix drives the delay below zero
        drain();
        apply_cfg('0, '1, 14'h2000, 1'b0);
        paced_beat(1'b1, 1'b0);
        paced_beat(1'b0, 1'b0);
    endtask

    task automatic test_zero_delay_firing();
        // angle 0, fix 0: delay clamps to 0, gate rises on the crossing beat
        drain();
        apply_cfg('0, 13'd6000, '0, 1'b1);
        paced_beat(1'b1, 1'b1);
        paced_beat(1'b1, 1'b0);
        paced_beat(1'b0, 1'b1);
        paced_beat(1'b1, 1'b1);
    endtask

    task automatic test_write_while_firing();
        // disable and new timing mid-pulse: the current cycle runs to its end
        drain();
        apply_cfg(15'd18000, 13'd4500, 14'd5000, 1'b0);
        paced_beat(1'b0, 1'b1);
        paced_beat(1'b1, 1'b1);
        paced_beat(1'b0, 1'b0);
    endtask

    task automatic test_output_backpressure();
        drain();
        hold_reqs++;
        repeat (30)
            send_beat(1'($urandom_range(0, 1)), 1'b1);
        while (hold_served != hold_reqs)
            @(posedge i_clk);
        drain();
    endtask

    task automatic run_out_firing();
        while (trig_running)
            paced_beat($urandom_range(0, 7) == 0, $urandom_range(0, 7) != 0);
    endtask

    task automatic test_idle_noise();
        drain();
        apply_cfg(ANGLE_BITS'($urandom_range(0, 32767)), FREQ_BITS'($urandom_range(0, 8191)),
                  FIX_BITS'($urandom_range(0, 16383)), 1'b0);
        repeat (40)
            paced_beat(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    task automatic test_random_firing();
        int   angle;
        int   freq;
        int   base;
        int   target;
        int   fix;
        int   mid_at;
        int   n;
        logic zc;
        logic tk;
        run_out_firing();
        drain();
        // pick the fix so that the delay lands near a small target
        angle  = $urandom_range(0, 8000);
        freq   = $urandom_range(4500, 6500);
        target = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : $urandom_range(0, 300);
        base   = angle * patf_pkg::ANGLE_SCALE / (patf_pkg::FREQ_SCALE * freq);
        fix    = (target + 1 - base) / 2;
        apply_cfg(ANGLE_BITS'(angle), FREQ_BITS'(freq), FIX_BITS'(fix), 1'b1);
        repeat ($urandom_range(0, 4))
            paced_beat(1'b0, 1'($urandom_range(0, 1)));
        paced_beat(1'b1, 1'($urandom_range(0, 1)));
        mid_at = $urandom_range(0, 1) ? $urandom_range(1, 350) : -1;
        n = 0;
        while (trig_running) begin
            if (n == mid_at) begin
                drain();
                apply_cfg(ANGLE_BITS'($urandom_range(0, 18000)), cfg_freq, cfg_fix, 1'b0);
            end
            zc = ($urandom_range(0, 5) == 0);
            tk = ($urandom_range(0, 7) != 0);
            // aim a crossing at the beat that ends the pulse
            if (tk && (trig_count + 1'b1) == trig_delay + CW'(PULSE))
                zc = 1'($urandom_range(0, 1));
            paced_beat(zc, tk);
            n++;
        end
        repeat (3)
            paced_beat(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    initial begin
        trigger_reset();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_register_extremes();
        test_zero_delay_firing();
        test_write_while_firing();
        test_output_backpressure();
        test_idle_noise();
        test_random_firing();
        test_idle_noise();

        drain();
        repeat (40) @(posedge i_clk);
        $display("Sent %0d input beats, checked %0d result beats, %0d register updates.",
                 beats_sent, results_checked, cfg_updates);
        $display("Predicted %0d gate pulses and %0d completed firing cycles.",
                 gate_pulses, firings_done);
        if (error_count == 0 && level_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> files.f
+incdir+src
src/patf_pkg.sv
src/patf_ctrl.sv
src/patf_dp.sv
src/phase_angle_triac_firing.sv
tb/sv/tb_top.sv
